// ===== rtl/rrq_pkg.sv =====
// Shared types and constants for the report retry queue.
// Used by the front end, the request queue, the back end and the top level.
package rrq_pkg;

	// Field widths of a keyboard report and its time stamp.
	localparam int MOD_W    = 8;
	localparam int KEYS_W   = 48;
	localparam int REPORT_W = MOD_W + KEYS_W;
	localparam int TIME_W   = 32;
	localparam int TOUT_W   = 16;
	localparam int QUEUED_W = 6;

	// Reset value of the timeout register, in milliseconds.
	localparam logic [TOUT_W-1:0] TIMEOUT_RESET = 16'd1000;

	// Register indexes on the configuration port.
	localparam logic REG_TIMEOUT = 1'b0;

	// Request command codes.
	localparam logic CMD_REPORT = 1'b0;
	localparam logic CMD_POLL   = 1'b1;

	// Result kinds.
	typedef enum logic [1:0] {
		KIND_SENT     = 2'd0,
		KIND_AGED     = 2'd1,
		KIND_OVERFLOW = 2'd2,
		KIND_STATUS   = 2'd3
	} kind_t;

	// Back end sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_CHECK,
		ST_NEW,
		ST_STATUS
	} back_state_t;

	// One classified request as it travels from the front to the back.
	typedef struct packed {
		logic                poll;
		logic                ready;
		logic [MOD_W-1:0]    modifier;
		logic [KEYS_W-1:0]   keys;
		logic [TIME_W-1:0]   now;
	} req_t;

	// One retry queue entry: the report and its arrival time.
	typedef struct packed {
		logic [MOD_W-1:0]    modifier;
		logic [KEYS_W-1:0]   keys;
		logic [TIME_W-1:0]   stamp;
	} entry_t;

	// Status of the request queue seen by its two sides.
	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

endpackage

// ===== rtl/rrq_front.sv =====
// Front end: takes requests on the command port, classifies them and pushes
// them into the request queue. Also holds the timeout register. Uses rrq_pkg.
module rrq_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          cmd,
	input  logic [rrq_pkg::MOD_W-1:0]     modifier_bits,
	input  logic [rrq_pkg::KEYS_W-1:0]    key_codes,
	input  logic [rrq_pkg::TIME_W-1:0]    now_ms,
	input  logic                          sink_ready,
	input  rrq_pkg::qstat_t               qstat,
	output logic                          push,
	output rrq_pkg::req_t                 push_req,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [2:0]                    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	output logic [rrq_pkg::TOUT_W-1:0]    timeout
);
	import rrq_pkg::*;

	logic [TOUT_W-1:0] timeout_q;
	logic              reg_write;

	// A request is taken whenever the queue has room.
	assign busy = qstat.full;
	assign push = start && !busy;

	// Classify the request; a poll carries no report.
	always_comb begin
		push_req.poll     = (cmd == CMD_POLL);
		push_req.ready    = sink_ready;
		push_req.now      = now_ms;
		if (cmd == CMD_POLL) begin
			push_req.modifier = '0;
			push_req.keys     = '0;
		end else begin
			push_req.modifier = modifier_bits;
			push_req.keys     = key_codes;
		end
	end

	// Configuration port: the access phase of a write updates the register.
	assign pready    = 1'b1;
	assign reg_write = psel && penable && pwrite && pready && (paddr[2] == REG_TIMEOUT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (reg_write) begin
			timeout_q <= pwdata[TOUT_W-1:0];
		end
	end

	always_comb begin
		if (paddr[2] == REG_TIMEOUT) begin
			prdata = {{(32-TOUT_W){1'b0}}, timeout_q};
		end else begin
			prdata = '0;
		end
	end

	assign timeout = timeout_q;

endmodule

// ===== rtl/rrq_cmd_queue.sv =====
// Two-entry request queue between the front and the back end.
// Uses rrq_pkg for the request type.
module rrq_cmd_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  rrq_pkg::req_t   push_req,
	input  logic            pop,
	output rrq_pkg::req_t   pop_req,
	output rrq_pkg::qstat_t qstat
);
	import rrq_pkg::*;

	req_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign qstat.full  = (count_q == 2'd2);
	assign qstat.empty = (count_q == 2'd0);
	assign pop_req     = slot_q[rd_ptr_q];

	// Request storage; written only on push.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_req;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

`ifndef SYNTHESIS
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty) else $error("request queue popped while empty");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !qstat.full) else $error("request queue pushed while full");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3) else $error("request queue count out of range");
`endif

endmodule

// ===== rtl/rrq_back.sv =====
// Back end: drains the retry queue, sends or queues the new report and
// emits at most one result per cycle. Holds the report store. Uses rrq_pkg.
module rrq_back #(
	parameter int DEPTH = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rrq_pkg::qstat_t               qstat,
	input  rrq_pkg::req_t                 pop_req,
	output logic                          pop,
	input  logic [rrq_pkg::TOUT_W-1:0]    timeout,
	output logic                          result_valid,
	output rrq_pkg::kind_t                kind,
	output logic [rrq_pkg::MOD_W-1:0]     out_modifier,
	output logic [rrq_pkg::KEYS_W-1:0]    out_keys,
	output logic [rrq_pkg::QUEUED_W-1:0]  queued,
	output logic                          last
);
	import rrq_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] n;
		n = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
		return n;
	endfunction

	back_state_t       state_q, state_d;
	logic [PTR_W-1:0]  head_q, head_d;
	logic [PTR_W-1:0]  tail_q, tail_d;
	logic [CNT_W-1:0]  fill_q, fill_d;
	req_t              cur_q;
	entry_t            rd_q;
	entry_t            store [DEPTH];

	logic              wr_en;
	entry_t            wr_entry;
	logic [TIME_W-1:0] age;
	logic              too_old;

	logic              emit;
	kind_t             e_kind;
	logic [MOD_W-1:0]  e_mod;
	logic [KEYS_W-1:0] e_keys;
	logic [CNT_W-1:0]  e_queued;
	logic              e_last;

	logic              res_valid_q;
	kind_t             res_kind_q;
	logic [MOD_W-1:0]  res_mod_q;
	logic [KEYS_W-1:0] res_keys_q;
	logic [CNT_W-1:0]  res_queued_q;
	logic              res_last_q;

	// Age of the head entry, modulo 2^32 so that time wraps cleanly.
	assign age     = cur_q.now - rd_q.stamp;
	assign too_old = age > {{(TIME_W-TOUT_W){1'b0}}, timeout};

	assign wr_entry.modifier = cur_q.modifier;
	assign wr_entry.keys     = cur_q.keys;
	assign wr_entry.stamp    = cur_q.now;

	// Sequencer: next state, pointer updates and the result to emit.
	always_comb begin
		state_d  = state_q;
		head_d   = head_q;
		tail_d   = tail_q;
		fill_d   = fill_q;
		pop      = 1'b0;
		wr_en    = 1'b0;
		emit     = 1'b0;
		e_kind   = KIND_STATUS;
		e_mod    = '0;
		e_keys   = '0;
		e_queued = fill_q;
		e_last   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (!qstat.empty) begin
					pop     = 1'b1;
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				if (fill_q == '0) begin
					state_d = ST_NEW;
				end else begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (too_old || cur_q.ready) begin
					emit     = 1'b1;
					e_kind   = too_old ? KIND_AGED : KIND_SENT;
					e_mod    = rd_q.modifier;
					e_keys   = rd_q.keys;
					head_d   = advance(head_q);
					fill_d   = fill_q - CNT_W'(1);
					e_queued = fill_d;
					state_d  = ST_READ;
				end else begin
					state_d = ST_NEW;
				end
			end
			ST_NEW: begin
				if (!cur_q.poll) begin
					if (cur_q.ready) begin
						emit   = 1'b1;
						e_kind = KIND_SENT;
						e_mod  = cur_q.modifier;
						e_keys = cur_q.keys;
					end else begin
						// Queue the report; a full queue loses its oldest entry first.
						wr_en  = 1'b1;
						tail_d = advance(tail_q);
						if (fill_q == CNT_FULL) begin
							emit     = 1'b1;
							e_kind   = KIND_OVERFLOW;
							e_mod    = rd_q.modifier;
							e_keys   = rd_q.keys;
							e_queued = fill_q - CNT_W'(1);
							head_d   = advance(head_q);
						end else begin
							fill_d = fill_q + CNT_W'(1);
						end
					end
				end
				state_d = ST_STATUS;
			end
			ST_STATUS: begin
				emit     = 1'b1;
				e_kind   = KIND_STATUS;
				e_last   = 1'b1;
				e_queued = fill_q;
				state_d  = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			fill_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			head_q      <= head_d;
			tail_q      <= tail_d;
			fill_q      <= fill_d;
			res_valid_q <= emit;
		end
	end

	// Current request and result payload.
	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= pop_req;
		end
		if (emit) begin
			res_kind_q   <= e_kind;
			res_mod_q    <= e_mod;
			res_keys_q   <= e_keys;
			res_queued_q <= e_queued;
			res_last_q   <= e_last;
		end
	end

	// Report store: written at the tail, read at the head with a registered read.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			store[tail_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk) begin
		rd_q <= store[head_q];
	end

	assign result_valid = res_valid_q;
	assign kind         = res_kind_q;
	assign out_modifier = res_mod_q;
	assign out_keys     = res_keys_q;
	assign queued       = QUEUED_W'(res_queued_q);
	assign last         = res_last_q;

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_FULL) else $error("retry queue fill above depth");
	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q == '0 |-> head_q == tail_q) else $error("empty queue with pointers apart");
	a_status_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_last_q |-> state_q == ST_IDLE)
		else $error("status result while request still in progress");
	a_pop_starts: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> state_q == ST_READ) else $error("popped request not started");
`endif

endmodule

// ===== rtl/report_retry_queue_unit.sv =====
// Top level of the keyboard report retry queue.
// Joins rrq_front, rrq_cmd_queue and rrq_back; uses rrq_pkg.
//
// Channel      Direction  Handshake                    Payload
// request      in         start / busy                 cmd, modifier_bits, key_codes,
//                                                       now_ms, sink_ready
// result       out        result_valid (one cycle)     kind, out_modifier, out_keys,
//                                                       queued, last
// config       in/out     APB psel/penable/pwrite      paddr, pwdata, prdata, pready
//
// A request passes the front combinationally into a two-entry queue; busy is
// high only while that queue is full. The back end drains the retry queue,
// each drained entry costing one store read and one age check, then handles
// the new report. Results come out at most one per cycle and cannot be stalled.
// Reset clears pointers and counts and sets the timeout register to 1000.
module report_retry_queue_unit #(
	parameter int DEPTH = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          cmd,
	input  logic [rrq_pkg::MOD_W-1:0]     modifier_bits,
	input  logic [rrq_pkg::KEYS_W-1:0]    key_codes,
	input  logic [rrq_pkg::TIME_W-1:0]    now_ms,
	input  logic                          sink_ready,
	output logic                          result_valid,
	output rrq_pkg::kind_t                kind,
	output logic [rrq_pkg::MOD_W-1:0]     out_modifier,
	output logic [rrq_pkg::KEYS_W-1:0]    out_keys,
	output logic [rrq_pkg::QUEUED_W-1:0]  queued,
	output logic                          last,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [2:0]                    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import rrq_pkg::*;

	qstat_t            qstat;
	logic              push;
	logic              pop;
	req_t              push_req;
	req_t              pop_req;
	logic [TOUT_W-1:0] timeout;

	// Request intake and configuration register.
	rrq_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.cmd           (cmd),
		.modifier_bits (modifier_bits),
		.key_codes     (key_codes),
		.now_ms        (now_ms),
		.sink_ready    (sink_ready),
		.qstat         (qstat),
		.push          (push),
		.push_req      (push_req),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.timeout       (timeout)
	);

	// Short queue that lets front and back stall independently.
	rrq_cmd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_req (push_req),
		.pop      (pop),
		.pop_req  (pop_req),
		.qstat    (qstat)
	);

	// Retry queue engine.
	rrq_back #(
		.DEPTH (DEPTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.qstat        (qstat),
		.pop_req      (pop_req),
		.pop          (pop),
		.timeout      (timeout),
		.result_valid (result_valid),
		.kind         (kind),
		.out_modifier (out_modifier),
		.out_keys     (out_keys),
		.queued       (queued),
		.last         (last)
	);

endmodule
